/* hdl/assert_macros.svh */
// Assertion macros used by the port-level checker, swrm_checker.sv.
// Each macro samples on clk and is disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SWRM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SWRM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/swrm_pkg.sv */
`timescale 1ns / 1ps
// Package for the sliding window rate meter: sizes, register codes, payload types.
// No dependencies; used by every module of the block except swrm_ram.
package swrm_pkg;

  localparam int DEPTH    = 4096;
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int CNT_W    = $clog2(DEPTH + 1);

  localparam int STAMP_W  = 48;
  localparam int VAL_W    = 32;
  localparam int WIN_W    = 20;
  localparam int RES_W    = 32;
  localparam int SCNT_W   = 17;
  localparam int ENTRY_W  = STAMP_W + VAL_W;

  localparam int SUM_W    = VAL_W + CNT_W;
  localparam int DIVD_W   = SUM_W + 3;
  localparam int DIV_CNT_W = $clog2(DIVD_W + 1);

  localparam int RATE_K_W = 14;
  localparam logic [RATE_K_W-1:0] RATE_K = 14'd16000;
  localparam int PROD_W   = CNT_W + RATE_K_W;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = WIN_W;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_MS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KBIT_MODE = 2'd1;
  localparam logic [WIN_W-1:0] WINDOW_RESET = 20'd5000;
  localparam logic KBIT_RESET = 1'b1;

  localparam logic REQ_RECORD = 1'b0;
  localparam logic REQ_QUERY  = 1'b1;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic               req_type;
    logic [STAMP_W-1:0] now_ms;
    logic [VAL_W-1:0]   sample_value;
  } req_t;

  typedef struct packed {
    logic [RES_W-1:0]  result_value;
    logic [SCNT_W-1:0] sample_count;
    logic [RES_W-1:0]  rate_q4;
  } rsp_t;

  typedef enum logic {
    OP_RECORD,
    OP_QUERY
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [STAMP_W-1:0] now_ms;
    logic [VAL_W-1:0]   value;
  } cmd_t;

  typedef struct packed {
    logic [WIN_W-1:0] window_ms;
    logic             kbit_mode;
  } cfg_t;

  function automatic logic [RES_W-1:0] sat_res(input logic [DIVD_W-1:0] q);
    logic [RES_W-1:0] r;
    if (|q[DIVD_W-1:RES_W]) begin
      r = '1;
    end else begin
      r = q[RES_W-1:0];
    end
    return r;
  endfunction

endpackage

/* hdl/swrm_ram.sv */
`timescale 1ns / 1ps
// Generic single-clock RAM: one write port, one read port with registered data.
// No dependencies.
module swrm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hdl/swrm_div.sv */
`timescale 1ns / 1ps
// Iterative restoring divider, one quotient bit per cycle.
// Depends on swrm_pkg for operand widths.
module swrm_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [swrm_pkg::DIVD_W-1:0] dividend,
  input  logic [swrm_pkg::WIN_W-1:0]  divisor,
  output logic                        done,
  output logic [swrm_pkg::DIVD_W-1:0] quot
);
  import swrm_pkg::*;

  logic                 busy;
  logic [DIV_CNT_W-1:0] bit_cnt;
  logic [WIN_W-1:0]     rem;
  logic [WIN_W-1:0]     dvsr;
  logic [WIN_W:0]       rem_sh;
  logic [WIN_W:0]       diff;
  logic                 ge;

  assign rem_sh = {rem, quot[DIVD_W-1]};
  assign diff   = rem_sh - {1'b0, dvsr};
  assign ge     = !diff[WIN_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= !start && busy && (bit_cnt == DIV_CNT_W'(1));
      if (start) begin
        busy    <= 1'b1;
        quot    <= dividend;
        rem     <= '0;
        dvsr    <= divisor;
        bit_cnt <= DIV_CNT_W'(DIVD_W);
      end else if (busy) begin
        rem     <= ge ? diff[WIN_W-1:0] : rem_sh[WIN_W-1:0];
        quot    <= {quot[DIVD_W-2:0], ge};
        bit_cnt <= bit_cnt - 1'b1;
        if (bit_cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

/* hdl/swrm_front.sv */
`timescale 1ns / 1ps
// Front end: configuration registers, request classification and command queue.
// Depends on swrm_pkg.
module swrm_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            req_valid,
  output logic                            req_stall,
  input  swrm_pkg::req_t                  req,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [swrm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [swrm_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                            cmd_valid,
  output swrm_pkg::cmd_t                  cmd,
  input  logic                            cmd_pop,
  output swrm_pkg::cfg_t                  cfg
);
  import swrm_pkg::*;

  cmd_t              q_mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] q_cnt;
  logic              push;
  logic              pop;
  cmd_t              new_cmd;

  assign cfg_ready = 1'b1;
  assign req_stall = (q_cnt == QCNT_W'(QUEUE_DEPTH));
  assign push      = req_valid && !req_stall;
  assign cmd_valid = (q_cnt != '0);
  assign pop       = cmd_pop && cmd_valid;
  assign cmd       = q_mem[rd_ptr];

  always_comb begin
    new_cmd.now_ms = req.now_ms;
    if (req.req_type == REQ_QUERY) begin
      new_cmd.op    = OP_QUERY;
      new_cmd.value = '0;
    end else begin
      new_cmd.op    = OP_RECORD;
      new_cmd.value = req.sample_value;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= new_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr        <= '0;
      rd_ptr        <= '0;
      q_cnt         <= '0;
      cfg.window_ms <= WINDOW_RESET;
      cfg.kbit_mode <= KBIT_RESET;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        q_cnt <= q_cnt + 1'b1;
      end else if (pop && !push) begin
        q_cnt <= q_cnt - 1'b1;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_WINDOW_MS: begin
            // a zero window acts as one millisecond
            cfg.window_ms <= (cfg_data == '0) ? WIN_W'(1) : cfg_data;
          end
          REG_KBIT_MODE: begin
            cfg.kbit_mode <= cfg_data[0];
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

/* hdl/swrm_back.sv */
`timescale 1ns / 1ps
// Back end: sample ring in RAM, backward window scan, divisions, result register.
// Depends on swrm_pkg, swrm_ram and swrm_div.
module swrm_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  input  swrm_pkg::cmd_t cmd,
  output logic           cmd_pop,
  input  swrm_pkg::cfg_t cfg,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output swrm_pkg::rsp_t rsp
);
  import swrm_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MUL,
    ST_DIV_RES,
    ST_DIV_RATE,
    ST_DONE
  } state_t;

  state_t               state;
  logic [ADDR_W-1:0]    wr_ptr;
  logic [ADDR_W-1:0]    wr_prev;
  logic [ADDR_W-1:0]    wr_next;
  logic [CNT_W-1:0]     fill_cnt;
  logic [ADDR_W-1:0]    ptr;
  logic [ADDR_W-1:0]    ptr_dec;
  logic [CNT_W-1:0]     issue_cnt;
  logic                 rd_pend;
  logic [CNT_W-1:0]     count;
  logic [SUM_W-1:0]     sum;
  logic signed [STAMP_W:0] lim;
  logic                 kbit_q;
  logic [WIN_W-1:0]     win_q;
  logic [PROD_W-1:0]    prod;
  logic [RES_W-1:0]     res_q;
  logic [RES_W-1:0]     rate_q;
  logic                 div_start;
  logic [DIVD_W-1:0]    div_dividend;
  logic [WIN_W-1:0]     div_divisor;
  logic                 div_done;
  logic [DIVD_W-1:0]    div_quot;

  logic                 ram_we;
  logic                 rd_en;
  logic [ENTRY_W-1:0]   rd_data;
  logic [STAMP_W-1:0]   rd_stamp;
  logic [VAL_W-1:0]     rd_value;
  logic                 in_win;
  logic                 last_entry;
  logic                 scan_stop;
  logic                 out_free;

  assign wr_prev    = (wr_ptr == '0) ? ADDR_W'(DEPTH - 1) : wr_ptr - 1'b1;
  assign wr_next    = (wr_ptr == ADDR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
  assign ptr_dec    = (ptr == '0) ? ADDR_W'(DEPTH - 1) : ptr - 1'b1;

  assign cmd_pop    = (state == ST_IDLE) && cmd_valid;
  assign ram_we     = cmd_pop && (cmd.op == OP_RECORD);

  assign rd_stamp   = rd_data[ENTRY_W-1:VAL_W];
  assign rd_value   = rd_data[VAL_W-1:0];
  assign in_win     = $signed({1'b0, rd_stamp}) > lim;
  // stop at the oldest written entry
  assign last_entry = (count == fill_cnt - 1'b1);
  assign scan_stop  = rd_pend && (!in_win || last_entry);
  assign rd_en      = (state == ST_SCAN) && (issue_cnt != fill_cnt) && !scan_stop;
  assign out_free   = !rsp_valid || !rsp_stall;

  swrm_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(DEPTH)
  ) u_ring (
    .clk  (clk),
    .we   (ram_we),
    .waddr(wr_ptr),
    .wdata({cmd.now_ms, cmd.value}),
    .re   (rd_en),
    .raddr(ptr),
    .rdata(rd_data)
  );

  swrm_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(div_dividend),
    .divisor (div_divisor),
    .done    (div_done),
    .quot    (div_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      wr_ptr    <= '0;
      fill_cnt  <= '0;
      rd_pend   <= 1'b0;
      div_start <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      div_start <= ((state == ST_MUL) && (count != '0))
                   || ((state == ST_DIV_RES) && div_done);
      rd_pend   <= rd_en;
      if (rsp_valid && !rsp_stall && (state != ST_DONE)) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (cmd_valid) begin
            if (cmd.op == OP_RECORD) begin
              wr_ptr <= wr_next;
              if (fill_cnt != CNT_W'(DEPTH)) begin
                fill_cnt <= fill_cnt + 1'b1;
              end
            end else begin
              // entry is inside the window when its stamp is above now - window
              lim <= $signed({1'b0, cmd.now_ms})
                     - $signed({{(STAMP_W + 1 - WIN_W){1'b0}}, cfg.window_ms});
              kbit_q    <= cfg.kbit_mode;
              win_q     <= cfg.window_ms;
              ptr       <= wr_prev;
              issue_cnt <= '0;
              count     <= '0;
              sum       <= '0;
              state     <= (fill_cnt == '0) ? ST_MUL : ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (rd_en) begin
            ptr       <= ptr_dec;
            issue_cnt <= issue_cnt + 1'b1;
          end
          if (rd_pend && in_win) begin
            sum   <= sum + SUM_W'(rd_value);
            count <= count + 1'b1;
          end
          if (scan_stop) begin
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          if (count == '0) begin
            res_q  <= '0;
            rate_q <= '0;
            state  <= ST_DONE;
          end else begin
            prod <= PROD_W'(count) * PROD_W'(RATE_K);
            if (kbit_q) begin
              div_dividend <= {sum, 3'b000};
              div_divisor  <= win_q;
            end else begin
              div_dividend <= DIVD_W'(sum);
              div_divisor  <= WIN_W'(count);
            end
            state <= ST_DIV_RES;
          end
        end
        ST_DIV_RES: begin
          if (div_done) begin
            res_q        <= sat_res(div_quot);
            div_dividend <= DIVD_W'(prod);
            div_divisor  <= win_q;
            state        <= ST_DIV_RATE;
          end
        end
        ST_DIV_RATE: begin
          if (div_done) begin
            rate_q <= sat_res(div_quot);
            state  <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            rsp_valid        <= 1'b1;
            rsp.result_value <= res_q;
            rsp.sample_count <= SCNT_W'(count);
            rsp.rate_q4      <= rate_q;
            state            <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

/* hdl/sliding_window_rate_meter_core.sv */
`timescale 1ns / 1ps
// Top level of the sliding window rate meter: front end and back end joined by a command queue.
// Depends on swrm_pkg, swrm_front and swrm_back.
//
//  channel  handshake             payload                     direction
//  req      req_valid / req_stall req (req_t)                 in
//  rsp      rsp_valid / rsp_stall rsp (rsp_t)                 out
//  cfg      cfg_valid / cfg_ready cfg_index, cfg_data         in
//
// A record is written to the ring while the back end stays idle. A query reads the ring
// through one RAM read port, one entry per cycle, bounded by the fill count; when any entry
// lies in the window, two serial divisions follow, for the result and then for the rate.
// Reset clears pointers, fill count, queue and result valid; the RAM is not cleared.
// The queue holds four requests, so req_stall rises only when it is full; a stalled result
// holds in the output register while the next query's result waits in ST_DONE.
module sliding_window_rate_meter_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            req_valid,
  output logic                            req_stall,
  input  swrm_pkg::req_t                  req,
  output logic                            rsp_valid,
  input  logic                            rsp_stall,
  output swrm_pkg::rsp_t                  rsp,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [swrm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [swrm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import swrm_pkg::*;

  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;
  cfg_t cfg;

  swrm_front u_front (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .cmd_valid(cmd_valid),
    .cmd      (cmd),
    .cmd_pop  (cmd_pop),
    .cfg      (cfg)
  );

  swrm_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd      (cmd),
    .cmd_pop  (cmd_pop),
    .cfg      (cfg),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

endmodule

/* hdl/swrm_checker.sv */
`timescale 1ns / 1ps
// Port-level checker for the rate meter, bound to the top level.
// Depends on swrm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module swrm_checker (
  input logic           clk,
  input logic           rst,
  input logic           rsp_valid,
  input logic           rsp_stall,
  input swrm_pkg::rsp_t rsp,
  input logic           cfg_valid,
  input logic           cfg_ready
);
  import swrm_pkg::*;

  `SWRM_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "stalled result changed")
  `SWRM_ASSERT_NOW(a_cfg_ready, cfg_valid, cfg_ready, "config write refused")
  `SWRM_ASSERT_NOW(a_count_max, rsp_valid, rsp.sample_count <= SCNT_W'(DEPTH), "count above ring size")
  `SWRM_ASSERT_NOW(a_empty_zero, rsp_valid && rsp.sample_count == '0, rsp.result_value == '0 && rsp.rate_q4 == '0, "empty window not zero")

endmodule

bind sliding_window_rate_meter_core swrm_checker u_swrm_checker (
  .clk      (clk),
  .rst      (rst),
  .rsp_valid(rsp_valid),
  .rsp_stall(rsp_stall),
  .rsp      (rsp),
  .cfg_valid(cfg_valid),
  .cfg_ready(cfg_ready)
);

/* sim/swrm_window_checker.sv */
`timescale 1ns / 1ps
// Window checker for sliding_window_rate_meter_core: mirrors the sample ring and the settings,
// works out each query's statistics and compares them with every result transfer.
// Depends on swrm_pkg.
module swrm_window_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            req_valid,
  input  logic                            req_stall,
  input  swrm_pkg::req_t                  req,
  input  logic                            rsp_valid,
  input  logic                            rsp_stall,
  input  swrm_pkg::rsp_t                  rsp,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [swrm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [swrm_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              pending,
  output int                              fault_count
);
  import swrm_pkg::*;

  localparam logic [63:0] Q4_RATE_SCALE = 64'd16000;
  localparam logic [63:0] U32_TOP = 64'hFFFF_FFFF;

  logic [STAMP_W-1:0] stamp_mem [DEPTH];
  logic [VAL_W-1:0]   value_mem [DEPTH];
  bit                 filled    [DEPTH];
  logic [ADDR_W-1:0]  wr_ptr;
  logic [WIN_W-1:0]   win_ms;
  logic               kbit_on;
  rsp_t               stats_due [$];
  int                 mismatches;

  function automatic logic [RES_W-1:0] clip32(input logic [63:0] v);
    return (v > U32_TOP) ? U32_TOP[RES_W-1:0] : v[RES_W-1:0];
  endfunction

  function automatic rsp_t window_stats(input logic [STAMP_W-1:0] now);
    rsp_t               r;
    logic [63:0]        span;
    logic [63:0]        total;
    logic [63:0]        hits;
    logic signed [63:0] age;
    logic [ADDR_W-1:0]  p;
    bit                 done;
    int                 i;
    span = win_ms;
    if (span == 0) span = 1;
    total = 0;
    hits = 0;
    done = 1'b0;
    p = wr_ptr - 1'b1;
    for (i = 0; i < DEPTH && !done; i++) begin
      age = $signed({16'd0, now}) - $signed({16'd0, stamp_mem[p]});
      if (!filled[p] || age >= $signed(span)) begin
        done = 1'b1;
      end else begin
        total = total + value_mem[p];
        hits = hits + 1;
        p = p - 1'b1;
      end
    end
    r = '0;
    if (hits != 0) begin
      r.result_value = kbit_on ? clip32((total << 3) / span) : clip32(total / hits);
      r.sample_count = hits[SCNT_W-1:0];
      r.rate_q4 = clip32((hits * Q4_RATE_SCALE) / span);
    end
    return r;
  endfunction

  task automatic flag(input string field, input logic [RES_W-1:0] want_v,
                      input logic [RES_W-1:0] got_v);
    $display("%0t: %s expected %h actual %h", $time, field, want_v, got_v);
    mismatches++;
  endtask

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      wr_ptr = '0;
      win_ms = WINDOW_RESET;
      kbit_on = KBIT_RESET;
      foreach (filled[k]) filled[k] = 1'b0;
      stats_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_WINDOW_MS) begin
          win_ms = cfg_data[WIN_W-1:0];
        end else if (cfg_index == REG_KBIT_MODE) begin
          kbit_on = cfg_data[0];
        end
      end
      if (rsp_valid && !rsp_stall) begin
        if (stats_due.size() == 0) begin
          $display("%0t: result transfer with none expected, actual %h", $time, rsp);
          mismatches++;
        end else begin
          want = stats_due.pop_front();
          if (rsp.result_value !== want.result_value)
            flag("result_value", want.result_value, rsp.result_value);
          if (rsp.sample_count !== want.sample_count)
            flag("sample_count", want.sample_count, rsp.sample_count);
          if (rsp.rate_q4 !== want.rate_q4)
            flag("rate_q4", want.rate_q4, rsp.rate_q4);
        end
      end
      if (req_valid && !req_stall) begin
        if (req.req_type == REQ_QUERY) begin
          stats_due.push_back(window_stats(req.now_ms));
        end else begin
          stamp_mem[wr_ptr] = req.now_ms;
          value_mem[wr_ptr] = req.sample_value;
          filled[wr_ptr] = 1'b1;
          wr_ptr = wr_ptr + 1'b1;
        end
      end
    end
    pending <= stats_due.size();
    fault_count <= mismatches + stats_due.size();
  end

endmodule

/* sim/sliding_window_rate_meter_core_tb.sv */
`timescale 1ns / 1ps
// Testbench top for sliding_window_rate_meter_core: clock, reset, sample and query traffic,
// register writes, result back-pressure, watchdog and verdict.
// Depends on swrm_pkg, sliding_window_rate_meter_core and swrm_window_checker.
module sliding_window_rate_meter_core_tb;
  import swrm_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;
  localparam int RAND_PHASES   = 5;
  localparam int PHASE_ITEMS   = 24;
  localparam int LONG_HOLD     = 600;
  localparam int SETTLE_CYCLES = 4300;
  localparam int STALL_LIMIT   = 20000;
  localparam logic [STAMP_W-1:0] STAMP_MAX = '1;

  logic                  clk;
  logic                  rst;
  logic                  req_valid;
  logic                  req_stall;
  req_t                  req;
  logic                  rsp_valid;
  logic                  rsp_stall;
  rsp_t                  rsp;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    pending;
  int                    fault_count;

  bit                    no_idle;
  int                    hold_token;
  int                    idle_cycles;
  logic [WIN_W-1:0]      cur_win;
  logic [STAMP_W-1:0]    t_clock;

  sliding_window_rate_meter_core dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  swrm_window_checker watcher (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .req         (req),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .rsp         (rsp),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .pending     (pending),
    .fault_count (fault_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    int unsigned hold_left;
    int          seen_hold;
    hold_left = 0;
    seen_hold = 0;
    rsp_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rsp_valid && !rsp_stall) hold_left = no_idle ? 0 : $urandom_range(0, 11);
      if (hold_token != seen_hold) begin
        seen_hold = hold_token;
        hold_left = LONG_HOLD;
      end
      if (hold_left != 0) begin
        rsp_stall <= 1'b1;
        hold_left--;
      end else begin
        rsp_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("sliding_window_rate_meter_core_tb: errors");
      $finish;
    end
  end

  function automatic logic [STAMP_W-1:0] rand_stamp();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[STAMP_W-1:0];
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2, 3, 4: return $urandom_range(0, 1500);
      default: return $urandom;
    endcase
  endfunction

  task automatic push_req(input req_t item);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req <= item;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
  endtask

  task automatic record(input logic [STAMP_W-1:0] stamp, input logic [VAL_W-1:0] v);
    req_t item;
    item.req_type = REQ_RECORD;
    item.now_ms = stamp;
    item.sample_value = v;
    push_req(item);
  endtask

  task automatic query(input logic [STAMP_W-1:0] now);
    req_t item;
    item.req_type = REQ_QUERY;
    item.now_ms = now;
    item.sample_value = $urandom;
    push_req(item);
  endtask

  task automatic settle();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    if (idx == REG_WINDOW_MS) cur_win = data;
  endtask

  task automatic random_item();
    int unsigned pick;
    int unsigned reach;
    reach = (cur_win == '0) ? 1 : cur_win;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      t_clock = t_clock + $urandom_range(0, reach / 3 + 1);
      record(t_clock, pick_value());
    end else if (pick < 80) begin
      query(t_clock + $urandom_range(0, reach / 2));
    end else if (pick < 88) begin
      record(t_clock + $urandom_range(1, reach), pick_value());
    end else if (pick < 94) begin
      record(rand_stamp(), pick_value());
    end else begin
      query(rand_stamp());
    end
  endtask

  initial begin
    int ph;
    int n;
    req_valid <= 1'b0;
    req <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    no_idle <= 1'b0;
    hold_token <= 0;
    rst <= 1'b1;
    cur_win = WINDOW_RESET;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    record('0, '1);
    query(STAMP_MAX);
    query(48'd5000);
    record(48'd10000, '0);
    record(48'd10001, '1);
    record(48'd14999, 32'd12345);
    query(48'd14999);
    query(48'd15000);
    record(48'd20000, 32'd7);
    query(48'd15000);
    settle();

    set_reg(REG_WINDOW_MS, '0);
    set_reg(REG_SPARE_3, '1);
    set_reg(REG_SPARE_2, '0);
    record(48'd30000, '1);
    record(48'd30000, '1);
    query(48'd30000);
    settle();
    set_reg(REG_KBIT_MODE, 20'hFFFFE);
    query(48'd30000);
    record(48'd29999, 32'd1);
    query(48'd30000);
    record(48'd30005, 32'd3);
    query(48'd30000);

    for (ph = 0; ph < RAND_PHASES; ph++) begin
      settle();
      case (ph)
        0: begin
          set_reg(REG_WINDOW_MS, 20'd1000000);
          set_reg(REG_KBIT_MODE, 20'd1);
        end
        1: begin
          set_reg(REG_WINDOW_MS, CFG_DATA_W'($urandom_range(2, 3000)));
          set_reg(REG_KBIT_MODE, '0);
        end
        2: begin
          set_reg(REG_WINDOW_MS, '1);
          set_reg(REG_KBIT_MODE, 20'd2);
        end
        3: begin
          set_reg(REG_WINDOW_MS, 20'd1);
          set_reg(REG_KBIT_MODE, 20'd1);
        end
        default: begin
          set_reg(REG_WINDOW_MS, CFG_DATA_W'($urandom));
          set_reg(REG_KBIT_MODE, CFG_DATA_W'($urandom));
        end
      endcase
      t_clock = rand_stamp() >> $urandom_range(0, 27);
      if (t_clock < 48'h20_0000) t_clock = t_clock + 48'h20_0000;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 1 && n == 8) hold_token <= hold_token + 1;
        if (ph == 2) no_idle <= (n < PHASE_ITEMS / 2);
        random_item();
      end
      no_idle <= 1'b0;
    end
    settle();

    if (fault_count == 0) begin
      $display("sliding_window_rate_meter_core_tb: clean");
    end else begin
      $display("sliding_window_rate_meter_core_tb: errors");
    end
    $finish;
  end

endmodule
